// File: src/crc32ms_pkg.sv
// Shared types, register indexes, constants and the byte-wide CRC update function.
package crc32ms_pkg;

  localparam int CfgIdxW = 2;
  localparam int TailLen = 4;
  localparam int SeenMax = 5;
  localparam int SeenW = 3;

  localparam logic [CfgIdxW-1:0] CfgIdxPoly = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxInit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxMode = 2'd2;

  localparam logic [31:0] PolyReset = 32'h04C11DB7;

  typedef struct packed {
    logic [31:0] polynomial;
    logic [31:0] initial_value;
    logic        check_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        check_passed;
  } res_t;

  typedef logic [TailLen-1:0][7:0] tail_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] a;
    a = acc ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      a = a[31] ? ({a[30:0], 1'b0} ^ poly) : {a[30:0], 1'b0};
    end
    return a;
  endfunction

endpackage

// File: src/crc32ms_byte_if.sv
// Channel that carries one message byte per transfer.
interface crc32ms_byte_if import crc32ms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/crc32ms_result_if.sv
// Channel that carries one CRC result per transfer.
interface crc32ms_result_if import crc32ms_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        check_passed;

  modport source (output valid, output result_value, output check_passed, input ready);
  modport sink (input valid, input result_value, input check_passed, output ready);
endinterface

// File: src/crc32ms_cfg_if.sv
// Channel that carries configuration register writes.
interface crc32ms_cfg_if import crc32ms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/crc32ms_engine.sv
// Message state and the per-byte CRC update, tail hold-back and check logic.
module crc32ms_engine import crc32ms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [31:0]    acc_q, acc_d;
  tail_t          tail_q, tail_d;
  logic [SeenW-1:0] seen_q, seen_d;

  logic [31:0]    acc_base;
  logic [31:0]    acc_new;
  logic [7:0]     hash_byte;
  logic           do_hash;
  tail_t          tail_new;
  logic [SeenW-1:0] seen_new;
  logic [31:0]    stored;
  logic           pass;

  always_comb begin
    if (seen_q == '0) begin
      acc_base = cfg_i.check_mode ? 32'h0 : cfg_i.initial_value;
    end else begin
      acc_base = acc_q;
    end
    hash_byte = cfg_i.check_mode ? tail_q[0] : data_byte_i;
    do_hash   = !cfg_i.check_mode || (seen_q >= SeenW'(TailLen));
    acc_new   = do_hash ? crc_byte(acc_base, hash_byte, cfg_i.polynomial) : acc_base;

    for (int k = 0; k < TailLen - 1; k++) begin
      tail_new[k] = tail_q[k+1];
    end
    tail_new[TailLen-1] = data_byte_i;

    seen_new = (seen_q < SeenW'(SeenMax)) ? seen_q + SeenW'(1) : seen_q;

    // The first held byte is the least significant byte of the stored CRC.
    stored = {tail_new[3], tail_new[2], tail_new[1], tail_new[0]};
    pass   = (seen_new >= SeenW'(SeenMax)) && (acc_new == stored);

    if (!cfg_i.check_mode) begin
      res_o.result_value = acc_new;
      res_o.check_passed = 1'b1;
    end else begin
      res_o.result_value = pass ? stored : 32'h0;
      res_o.check_passed = pass;
    end

    acc_d  = acc_q;
    tail_d = tail_q;
    seen_d = seen_q;
    if (step_i) begin
      acc_d = acc_new;
      if (last_byte_i) begin
        tail_d = '0;
        seen_d = '0;
      end else begin
        tail_d = tail_new;
        seen_d = seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      tail_q <= '0;
      seen_q <= '0;
    end else begin
      acc_q  <= acc_d;
      tail_q <= tail_d;
      seen_q <= seen_d;
    end
  end

endmodule

// File: src/crc32_msb_stream_checker_top.sv
// Top level of the MSB-first CRC-32 stream checker with input and result registers.
//
//   Channel     Direction  Transfer payload
//   byte_in     sink       data_byte[7:0], last_byte
//   result_out  source     result_value[31:0], check_passed
//   cfg_in      sink       index[1:0], data[31:0]
//
// One byte is taken every cycle while ready is high; the byte-wide CRC update
// between the input register and the result register sets that rate.
// A result is loaded into the result register when its last byte leaves the input register.
// Reset sets the configuration registers to polynomial 0x04C11DB7, seed 0, compute mode.
// Input ready drops only while a last byte waits behind a result that is not taken.
module crc32_msb_stream_checker_top import crc32ms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  crc32ms_byte_if.sink     byte_in,
  crc32ms_result_if.source result_out,
  crc32ms_cfg_if.sink      cfg_in
);

  cfg_t       cfg_q, cfg_d;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q, out_valid_d;
  res_t       res_q;
  res_t       res_next;

  logic       out_free;
  logic       s1_fire;
  logic       in_fire;
  logic       res_load;

  assign out_free = !out_valid_q || result_out.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign res_load = s1_fire && s1_last_q;

  assign byte_in.ready = !s1_valid_q || s1_fire;
  assign in_fire       = byte_in.valid && byte_in.ready;

  assign cfg_in.ready = 1'b1;

  assign result_out.valid        = out_valid_q;
  assign result_out.result_value = res_q.result_value;
  assign result_out.check_passed = res_q.check_passed;

  crc32ms_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .cfg_i       (cfg_q),
    .res_o       (res_next)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_in.valid) begin
      case (cfg_in.index)
        CfgIdxPoly: cfg_d.polynomial    = cfg_in.data;
        CfgIdxInit: cfg_d.initial_value = cfg_in.data;
        CfgIdxMode: cfg_d.check_mode    = cfg_in.data[0];
        default:    cfg_d = cfg_q;
      endcase
    end

    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (result_out.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{polynomial: PolyReset, initial_value: 32'h0, check_mode: 1'b0};
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= byte_in.data_byte;
      s1_last_q <= byte_in.last_byte;
    end
    if (res_load) begin
      res_q <= res_next;
    end
  end

  a_ready_low_only_when_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !byte_in.ready |-> (s1_valid_q && s1_last_q && out_valid_q && !result_out.ready)
  ) else $error("Input stalled without a waiting last byte behind a stalled result.");

  a_result_from_last_byte: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q)
  ) else $error("Result appeared without a last byte being processed.");

  a_fail_gives_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.check_passed) |-> (res_q.result_value == 32'h0)
  ) else $error("Failed check carries a nonzero CRC value.");

endmodule
